[hdl/mvms_pkg.sv]
// Shared types and constants for the matrix-vector multiply-subtract core
package mvms_pkg;

    localparam int DATA_W     = 16;
    localparam int PRIOR_W    = 32;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 48;
    localparam int ROW_W      = 16;
    localparam int COLCFG_W   = 9;
    localparam int VIDX_W     = 8;
    localparam int SUM_SHIFT  = 14;
    localparam int SCALED_W   = ACC_W - SUM_SHIFT;
    localparam int DIFF_W     = SCALED_W + 1;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 48;
    localparam int ACTION_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD = 2'd0,
        ACT_ROW  = 2'd1,
        ACT_ELEM = 2'd2
    } action_t;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

    typedef struct packed {
        logic                      first;
        logic                      complete;
        logic                      last_row;
        logic [ROW_W-1:0]          row_index;
        logic signed [PRIOR_W-1:0] prior;
    } meta_t;

endpackage

[hdl/mvms_ram.sv]
// Generic single-write, single-read RAM with registered read data
module mvms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/matrix_vector_multiply_subtract_core.sv]
// Top level of the streaming matrix-vector multiply-subtract core
//
// Usage: first load the vector with transactions of kind "load" (s_tuser),
// one element per transaction at vector_index. Each row then opens with a
// "row" transaction carrying the prior destination value, followed by the
// row's matrix elements in column order. The element that completes a row
// yields one result transaction: prior minus the row dot product, Q16.16,
// saturated, with its row number and m_tlast set on the final row.
// Configuration: cfg_wr_en writes row_count (index 0) or col_count (index 1)
// at any clock edge; write only while no result is pending.
// Throughput: one input transaction per cycle while s_tready is high. The
// completing element's vector read happens at the accepting edge; multiply,
// accumulate, and subtract-with-saturate are then registered in turn before
// the result appears on m_tvalid.
// Stall: a waiting result is held in the output register; input is still
// taken until a second result reaches the stage behind it, then the whole
// pipeline holds until m_tready.
// Reset: aresetn low clears positions, accumulator, pending results and sets
// both counts to 1. The vector store is not cleared and must be loaded.
module matrix_vector_multiply_subtract_core #(
    parameter int MAX_COLS = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mvms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mvms_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] vector_index, [23:8] element_value, [55:24] prior_value
    input  logic [mvms_pkg::S_TDATA_W-1:0]      s_tdata,
    // [1:0] action
    input  logic [mvms_pkg::ACTION_W-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] result_value, [47:32] row_index
    output logic [mvms_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);

    localparam int ADDR_W  = $clog2(MAX_COLS);
    localparam int CNT_W   = $clog2(MAX_COLS + 1);
    localparam int CMP_W   = (CNT_W > mvms_pkg::COLCFG_W) ? CNT_W : mvms_pkg::COLCFG_W;
    localparam int WIDX_W  = (CNT_W > mvms_pkg::VIDX_W) ? CNT_W : mvms_pkg::VIDX_W;
    localparam int ROW_W   = mvms_pkg::ROW_W;
    localparam int DATA_W  = mvms_pkg::DATA_W;
    localparam int PRIOR_W = mvms_pkg::PRIOR_W;
    localparam int ACC_W   = mvms_pkg::ACC_W;
    localparam int PROD_W  = mvms_pkg::PROD_W;
    localparam int DIFF_W  = mvms_pkg::DIFF_W;

    mvms_pkg::action_t          in_action;
    logic [mvms_pkg::VIDX_W-1:0] in_vidx;
    logic signed [DATA_W-1:0]   in_elem;
    logic signed [PRIOR_W-1:0]  in_prior;

    logic out_free;
    logic advance;
    logic accept;

    logic [ROW_W-1:0]              row_count_reg;
    logic [mvms_pkg::COLCFG_W-1:0] col_count_reg;

    logic [CNT_W-1:0]          col_pos_reg;
    logic [ROW_W-1:0]          row_pos_reg;
    logic signed [PRIOR_W-1:0] prior_latch_reg;

    logic [CMP_W-1:0] col_ext;
    logic [CMP_W-1:0] eff_cols;
    logic [CMP_W-1:0] col_inc;
    logic             row_done;
    logic [ROW_W-1:0] eff_rows;
    logic [ROW_W:0]   row_inc;
    logic             row_last;

    logic [WIDX_W-1:0] widx_ext;
    logic              ram_we;
    logic [DATA_W-1:0] ram_rdata;

    logic                     s1_valid_reg;
    mvms_pkg::meta_t          s1_meta_reg;
    logic signed [DATA_W-1:0] s1_elem_reg;

    logic                     s2_valid_reg;
    mvms_pkg::meta_t          s2_meta_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    logic                    s3_valid_reg;
    mvms_pkg::meta_t         s3_meta_reg;
    logic signed [ACC_W-1:0] s3_sum_reg;

    logic signed [mvms_pkg::SCALED_W-1:0] scaled;
    logic signed [DIFF_W-1:0]             diff;
    logic signed [PRIOR_W-1:0]            result_next;

    logic                      m_valid_reg;
    logic signed [PRIOR_W-1:0] m_result_reg;
    logic [ROW_W-1:0]          m_row_reg;
    logic                      m_last_reg;

    assign in_action = mvms_pkg::action_t'(s_tuser);
    assign in_vidx   = s_tdata[7:0];
    assign in_elem   = s_tdata[23:8];
    assign in_prior  = s_tdata[55:24];

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = out_free || !s3_valid_reg;
    assign accept   = s_tvalid && advance;
    assign s_tready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= ROW_W'(1);
            col_count_reg <= mvms_pkg::COLCFG_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mvms_pkg::CFG_ROW_COUNT: row_count_reg <= cfg_wdata[ROW_W-1:0];
                mvms_pkg::CFG_COL_COUNT: col_count_reg <= cfg_wdata[mvms_pkg::COLCFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        col_ext = CMP_W'(col_count_reg);
        if (col_ext == '0) begin
            eff_cols = CMP_W'(1);
        end else if (col_ext > CMP_W'(MAX_COLS)) begin
            eff_cols = CMP_W'(MAX_COLS);
        end else begin
            eff_cols = col_ext;
        end
        col_inc  = CMP_W'(col_pos_reg) + CMP_W'(1);
        row_done = col_inc >= eff_cols;
        eff_rows = (row_count_reg == '0) ? ROW_W'(1) : row_count_reg;
        row_inc  = {1'b0, row_pos_reg} + (ROW_W + 1)'(1);
        row_last = row_inc >= {1'b0, eff_rows};
    end

    assign widx_ext = WIDX_W'(in_vidx);
    assign ram_we   = accept && (in_action == mvms_pkg::ACT_LOAD)
                      && (widx_ext < WIDX_W'(MAX_COLS));

    mvms_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_COLS)
    ) u_vector_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (widx_ext[ADDR_W-1:0]),
        .wdata (in_elem),
        .re    (accept),
        .raddr (col_pos_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg     <= '0;
            row_pos_reg     <= '0;
            prior_latch_reg <= '0;
        end else if (accept) begin
            unique case (in_action)
                mvms_pkg::ACT_ROW: begin
                    prior_latch_reg <= in_prior;
                    col_pos_reg     <= '0;
                end
                mvms_pkg::ACT_ELEM: begin
                    if (row_done) begin
                        col_pos_reg <= '0;
                        row_pos_reg <= row_last ? '0 : row_inc[ROW_W-1:0];
                    end else begin
                        col_pos_reg <= col_inc[CNT_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            acc_reg      <= '0;
        end else if (advance) begin
            s1_valid_reg <= accept && (in_action == mvms_pkg::ACT_ELEM);
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg && s2_meta_reg.complete;
            if (s2_valid_reg) begin
                acc_reg <= s2_meta_reg.complete ? '0 : acc_next;
            end
        end
    end

    assign acc_next = (s2_meta_reg.first ? ACC_W'(0) : acc_reg) + ACC_W'(s2_prod_reg);

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_meta_reg.first     <= (col_pos_reg == '0);
            s1_meta_reg.complete  <= row_done;
            s1_meta_reg.last_row  <= row_last;
            s1_meta_reg.row_index <= row_pos_reg;
            s1_meta_reg.prior     <= prior_latch_reg;
            s1_elem_reg           <= in_elem;
            s2_meta_reg           <= s1_meta_reg;
            s2_prod_reg           <= s1_elem_reg * $signed(ram_rdata);
            s3_meta_reg           <= s2_meta_reg;
            s3_sum_reg            <= acc_next;
        end
    end

    always_comb begin
        scaled = s3_sum_reg[ACC_W-1:mvms_pkg::SUM_SHIFT];
        diff   = DIFF_W'(s3_meta_reg.prior) - DIFF_W'(scaled);
        if (!diff[DIFF_W-1] && (diff[DIFF_W-2:PRIOR_W-1] != '0)) begin
            result_next = {1'b0, {(PRIOR_W-1){1'b1}}};
        end else if (diff[DIFF_W-1] && (diff[DIFF_W-2:PRIOR_W-1] != '1)) begin
            result_next = {1'b1, {(PRIOR_W-1){1'b0}}};
        end else begin
            result_next = diff[PRIOR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && s3_valid_reg) begin
            m_result_reg <= result_next;
            m_row_reg    <= s3_meta_reg.row_index;
            m_last_reg   <= s3_meta_reg.last_row;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_row_reg, m_result_reg};
    assign m_tlast  = m_last_reg;

endmodule

[hdl/mvms_checker.sv]
// Port-level checker for the matrix-vector multiply-subtract core, with bind
module mvms_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mvms_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result transaction pending after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result transaction changed");

    a_input_open_when_output_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input held while output register is free");

    a_no_stall_without_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a blocked result");

endmodule

bind matrix_vector_multiply_subtract_core mvms_checker u_mvms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[test/tb_top.sv]
// Self-checking testbench for the streaming matrix-vector multiply-subtract core
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ACTION_W   = mvms_pkg::ACTION_W;
    localparam int PRIOR_W    = mvms_pkg::PRIOR_W;
    localparam int ROW_W      = mvms_pkg::ROW_W;
    localparam int CFG_IDX_W  = mvms_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = mvms_pkg::CFG_DATA_W;
    localparam int S_TDATA_W  = mvms_pkg::S_TDATA_W;
    localparam int M_TDATA_W  = mvms_pkg::M_TDATA_W;
    localparam int DATA_W     = mvms_pkg::DATA_W;
    localparam int ACC_W      = mvms_pkg::ACC_W;
    localparam int COLCFG_W   = mvms_pkg::COLCFG_W;
    localparam int VIDX_W     = mvms_pkg::VIDX_W;
    localparam int PROD_W     = mvms_pkg::PROD_W;
    localparam int SUM_SHIFT  = mvms_pkg::SUM_SHIFT;

    localparam int CLK_PERIOD = 8;
    localparam int VEC_DEPTH = 256;
    localparam int IDLE_PCT = 11;
    localparam int PIPE_FLUSH = 8;
    localparam int ITEM_GOAL = 1100;
    localparam int REPORT_LIMIT = 10;
    localparam longint TIMEOUT_NS = 2_000_000;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic signed [PRIOR_W-1:0] value;
        logic [ROW_W-1:0]          row;
        logic                      last;
    } row_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [ACTION_W-1:0]    s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;

    // predictor state
    logic signed [DATA_W-1:0]  vec_mem [VEC_DEPTH];
    bit                        vec_written [VEC_DEPTH];
    logic [ACC_W-1:0]          dot_acc = '0;
    int unsigned               col_pos = 0;
    logic [ROW_W-1:0]          row_pos = '0;
    logic signed [PRIOR_W-1:0] prior_latch = '0;
    logic [ROW_W-1:0]          row_cnt = 16'd1;
    logic [COLCFG_W-1:0]       col_cnt = 9'd1;

    row_result_t pending_row_results [$];
    int          mismatch_count = 0;
    int          items_accepted = 0;
    bit          sender_steady = 1'b0;
    bit          receiver_steady = 1'b0;

    matrix_vector_multiply_subtract_core #(.MAX_COLS(VEC_DEPTH)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= receiver_steady || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic int unsigned effective_cols(input logic [COLCFG_W-1:0] c);
        if (c == 0) return 1;
        if (c > VEC_DEPTH) return VEC_DEPTH;
        return c;
    endfunction

    function automatic void predict_item(input logic [ACTION_W-1:0] act,
                                         input logic [VIDX_W-1:0] vidx,
                                         input logic signed [DATA_W-1:0] elem,
                                         input logic signed [PRIOR_W-1:0] prior);
        int unsigned              eff_rows;
        logic signed [DATA_W-1:0] vec;
        logic signed [PROD_W-1:0] prod;
        longint                   sum;
        longint                   diff;
        row_result_t              res;
        case (act)
            mvms_pkg::ACT_LOAD: begin
                vec_mem[vidx] = elem;
                vec_written[vidx] = 1'b1;
            end
            mvms_pkg::ACT_ROW: begin
                prior_latch = prior;
                dot_acc = '0;
                col_pos = 0;
            end
            mvms_pkg::ACT_ELEM: begin
                vec = (col_pos < VEC_DEPTH) ? vec_mem[col_pos] : '0;
                prod = elem * vec;
                dot_acc = dot_acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
                col_pos++;
                if (col_pos >= effective_cols(col_cnt)) begin
                    eff_rows = (row_cnt == 0) ? 1 : row_cnt;
                    sum = {{(64 - ACC_W){dot_acc[ACC_W-1]}}, dot_acc};
                    diff = longint'(prior_latch) - (sum >>> SUM_SHIFT);
                    if (diff > 64'sd2147483647) diff = 64'sd2147483647;
                    if (diff < -64'sd2147483648) diff = -64'sd2147483648;
                    res.value = diff[PRIOR_W-1:0];
                    res.row = row_pos;
                    res.last = (int'(row_pos) + 1) >= eff_rows;
                    pending_row_results.push_back(res);
                    row_pos = res.last ? '0 : row_pos + 1'b1;
                    col_pos = 0;
                    dot_acc = '0;
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin
        row_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_row_results.size() == 0) begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("%0t: unexpected result value %0d row %0d last %0b", $realtime,
                             $signed(m_tdata[31:0]), m_tdata[47:32], m_tlast);
                mismatch_count++;
            end else begin
                exp_res = pending_row_results.pop_front();
                if (m_tdata[31:0] !== exp_res.value || m_tdata[47:32] !== exp_res.row
                        || m_tlast !== exp_res.last) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: mismatch exp value %0d row %0d last %0b, got %0d %0d %0b",
                                 $realtime, exp_res.value, exp_res.row, exp_res.last,
                                 $signed(m_tdata[31:0]), m_tdata[47:32], m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [VIDX_W-1:0] vidx,
                             input logic signed [DATA_W-1:0] elem,
                             input logic signed [PRIOR_W-1:0] prior);
        while (!sender_steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {prior, elem, vidx};
        do @(posedge aclk); while (!s_tready);
        predict_item(act, vidx, elem, prior);
        items_accepted++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_row_results.size() != 0) @(posedge aclk);
        repeat (PIPE_FLUSH) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        @(posedge aclk);
        case (idx)
            mvms_pkg::CFG_ROW_COUNT: row_cnt = value[ROW_W-1:0];
            mvms_pkg::CFG_COL_COUNT: col_cnt = value[COLCFG_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_elem();
        case ($urandom_range(7))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return '0;
            3: return -16'sd1;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [PRIOR_W-1:0] pick_prior();
        case ($urandom_range(7))
            0: return 32'sh8000_0000 + $urandom_range(1 << 25);
            1: return 32'sh7FFF_FFFF - $urandom_range(1 << 25);
            2: return '0;
            default: return PRIOR_W'($urandom);
        endcase
    endfunction

    task automatic send_elems(input int unsigned n);
        repeat (n) send_item(mvms_pkg::ACT_ELEM, VIDX_W'($urandom), pick_elem(),
                             PRIOR_W'($urandom));
    endtask

    task automatic send_row_start();
        send_item(mvms_pkg::ACT_ROW, VIDX_W'($urandom), DATA_W'($urandom), pick_prior());
    endtask

    task automatic load_vector(input int unsigned len, input bit reload_all);
        for (int i = 0; i < len; i++) begin
            if (reload_all || !vec_written[i])
                send_item(mvms_pkg::ACT_LOAD, VIDX_W'(i), pick_elem(), PRIOR_W'($urandom));
        end
        repeat ($urandom_range(2))
            send_item(mvms_pkg::ACT_LOAD, VIDX_W'($urandom), pick_elem(), PRIOR_W'($urandom));
    endtask

    task automatic send_row(input int unsigned eff);
        int unsigned cut;
        cut = $urandom_range(eff - 1);
        case ($urandom_range(19))
            0: begin
                send_item(ACT_UNUSED, VIDX_W'($urandom), pick_elem(), pick_prior());
                send_row_start();
                send_elems(eff);
            end
            1: send_elems(eff);
            2: begin
                send_row_start();
                send_elems(cut);
                send_row_start();
                send_elems(eff);
            end
            3: begin
                send_row_start();
                send_elems(cut);
                send_item(mvms_pkg::ACT_LOAD, VIDX_W'($urandom), pick_elem(),
                          PRIOR_W'($urandom));
                send_elems(eff - cut);
            end
            4: begin
                send_row_start();
                send_elems(cut);
            end
            default: begin
                send_row_start();
                send_elems(eff);
            end
        endcase
    endtask

    task automatic test_reset_state();
        send_item(mvms_pkg::ACT_LOAD, 8'd0, -16'sd32768, '0);
        send_item(mvms_pkg::ACT_ELEM, 8'd0, -16'sd32768, '0);
    endtask

    task automatic test_directed_extremes();
        wait_idle();
        cfg_write(mvms_pkg::CFG_COL_COUNT, 2);
        cfg_write(mvms_pkg::CFG_ROW_COUNT, 3);
        send_item(mvms_pkg::ACT_LOAD, 8'd1, 16'sd32767, '0);
        send_item(mvms_pkg::ACT_LOAD, 8'd255, 16'sh5555, 32'hFFFF_FFFF);
        send_item(mvms_pkg::ACT_ROW, '0, '0, 32'sh8000_0000);
        send_item(mvms_pkg::ACT_ELEM, '0, -16'sd32768, '0);
        send_item(mvms_pkg::ACT_ELEM, '0, 16'sd32767, '0);
        send_item(mvms_pkg::ACT_ROW, '0, '0, 32'sh7FFF_FFFF);
        send_item(mvms_pkg::ACT_ELEM, '0, 16'sd32767, '0);
        send_item(mvms_pkg::ACT_ELEM, '0, -16'sd32768, '0);
        send_item(mvms_pkg::ACT_ROW, '0, '0, '0);
        send_item(mvms_pkg::ACT_ELEM, '0, '0, '0);
        send_item(mvms_pkg::ACT_ELEM, '0, -16'sd1, '0);
        send_item(ACT_UNUSED, 8'hFF, -16'sd1, 32'hFFFF_FFFF);
        send_item(mvms_pkg::ACT_ROW, '0, '0, 32'sh3039_0000);
        send_item(mvms_pkg::ACT_ELEM, '0, 16'sd1, '0);
        send_item(mvms_pkg::ACT_ROW, '0, '0, -32'sd1);
        send_item(mvms_pkg::ACT_ELEM, '0, 16'sd32767, '0);
        send_item(mvms_pkg::ACT_ELEM, '0, 16'sd32767, '0);
    endtask

    task automatic test_config_corners();
        wait_idle();
        cfg_write(mvms_pkg::CFG_COL_COUNT, 0);
        cfg_write(mvms_pkg::CFG_ROW_COUNT, 0);
        send_row_start();
        send_elems(1);
        wait_idle();
        cfg_write(mvms_pkg::CFG_COL_COUNT, 3);
        load_vector(3, 1'b0);
        send_row_start();
        send_elems(2);
        // shrink the row under way: the next element closes it
        wait_idle();
        cfg_write(mvms_pkg::CFG_COL_COUNT, 1);
        send_elems(1);
        wait_idle();
        cfg_write(mvms_pkg::CFG_COL_COUNT, 511);
        cfg_write(mvms_pkg::CFG_ROW_COUNT, 65535);
        load_vector(VEC_DEPTH, 1'b0);
        send_row_start();
        send_elems(VEC_DEPTH);
    endtask

    task automatic test_random_rows();
        int          phase;
        int unsigned pick;
        int unsigned cols_cfg;
        int unsigned rows_cfg;
        int unsigned eff;
        int unsigned n_rows;
        phase = 0;
        while (items_accepted < ITEM_GOAL) begin
            wait_idle();
            pick = $urandom_range(99);
            if (pick < 70) cols_cfg = $urandom_range(1, 8);
            else if (pick < 95) cols_cfg = $urandom_range(9, 40);
            else if (pick < 98) cols_cfg = $urandom_range(41, VEC_DEPTH);
            else cols_cfg = $urandom_range(VEC_DEPTH + 1, 511);
            pick = $urandom_range(9);
            rows_cfg = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(1, 6);
            cfg_write(mvms_pkg::CFG_COL_COUNT, cols_cfg);
            if ($urandom_range(3) != 0) cfg_write(mvms_pkg::CFG_ROW_COUNT, rows_cfg);
            sender_steady = (phase >= 2 && phase < 5);
            receiver_steady = sender_steady;
            eff = effective_cols(col_cnt);
            load_vector(eff, $urandom_range(1));
            n_rows = (eff > 40) ? $urandom_range(1, 2) : $urandom_range(1, 8);
            repeat (n_rows) send_row(eff);
            phase++;
        end
        sender_steady = 1'b0;
        receiver_steady = 1'b0;
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_state();
        test_directed_extremes();
        test_config_corners();
        test_random_rows();
        wait_idle();
        if (mismatch_count == 0 && pending_row_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
